// ===== sv/lowest_free_slot_table_unit_assert.svh =====
// Assertion macros for the slot table unit.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef LOWEST_FREE_SLOT_TABLE_UNIT_ASSERT_SVH
`define LOWEST_FREE_SLOT_TABLE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LFST_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("slot table check failed");

`define LFST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot table check failed");

`define LFST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot table check failed");

`else

`define LFST_ASSERT_ALWAYS(label, clk, rst, cond)
`define LFST_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LFST_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/lfst_pkg.sv =====
`timescale 1ns / 1ps

package lfst_pkg;

   localparam int SLOTS     = 1024;
   localparam int SLOT_W    = 10;
   localparam int NEXT_W    = 11;
   localparam int VALUE_W   = 16;
   localparam int EVENTS_W  = 16;
   localparam int ENTRY_W   = VALUE_W + EVENTS_W;
   localparam int STATUS_W  = 2;
   localparam int DEF_ROW_W = 32;

   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_ABOVE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_CHECK,
      S_FINISH
   } state_type;

endpackage

// ===== sv/lfst_req_if.sv =====
`timescale 1ns / 1ps

interface lfst_req_if import lfst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [VALUE_W-1:0]  entry_value;
   logic [EVENTS_W-1:0] entry_events;
   logic [SLOT_W-1:0]   slot_index;

   modport source (output valid, mode, entry_value, entry_events, slot_index, input ready);
   modport sink   (input valid, mode, entry_value, entry_events, slot_index, output ready);
endinterface

// ===== sv/lfst_rsp_if.sv =====
`timescale 1ns / 1ps

interface lfst_rsp_if import lfst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   used_slot;
   logic [SLOT_W-1:0]   high_mark;
   logic [NEXT_W-1:0]   next_free;

   modport source (output valid, status, used_slot, high_mark, next_free, input ready);
   modport sink   (input valid, status, used_slot, high_mark, next_free, output ready);
endinterface

// ===== sv/lfst_valid_map.sv =====
`timescale 1ns / 1ps

module lfst_valid_map import lfst_pkg::*; #(
   parameter int ROW_W = DEF_ROW_W
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [SLOT_W-$clog2(ROW_W)-1:0]     wr_row,
   input  logic [ROW_W-1:0]                    wr_mask,
   input  logic [ROW_W-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [SLOT_W-$clog2(ROW_W)-1:0]     rd_row,
   output logic [ROW_W-1:0]                    rd_data
);

   localparam int ROWS = SLOTS / ROW_W;

   logic [ROW_W-1:0] map_mem [ROWS];
   logic [ROW_W-1:0] rd_data_ff;

   // bit-enable write: only masked bits of the row change
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < ROW_W; b++) begin
            if (wr_mask[b]) begin
               map_mem[wr_row][b] <= wr_data[b];
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lfst_find_free.sv =====
`timescale 1ns / 1ps

module lfst_find_free import lfst_pkg::*; #(
   parameter int ROW_W = DEF_ROW_W
) (
   input  logic [ROW_W-1:0]         row_bits,
   input  logic                     use_lo,
   input  logic [$clog2(ROW_W)-1:0] lo_bit,
   input  logic                     use_hi,
   input  logic [$clog2(ROW_W)-1:0] hi_bit,
   output logic                     found,
   output logic [$clog2(ROW_W)-1:0] pos
);

   localparam int BIT_W = $clog2(ROW_W);

   logic [ROW_W-1:0] cand;

   // free bits inside the window [lo_bit, hi_bit] of this row
   always_comb begin
      for (int b = 0; b < ROW_W; b++) begin
         cand[b] = !row_bits[b]
                   && (!use_lo || (BIT_W'(b) >= lo_bit))
                   && (!use_hi || (BIT_W'(b) <= hi_bit));
      end
   end

   // lowest candidate wins
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int b = ROW_W - 1; b >= 0; b--) begin
         if (cand[b]) begin
            found = 1'b1;
            pos   = BIT_W'(b);
         end
      end
   end

endmodule

// ===== sv/lowest_free_slot_table_unit.sv =====
// A remove runs S_EXEC, S_CHECK, S_FINISH (S_EXEC, S_FINISH when the index is above the mark);
// an add runs S_EXEC, S_FINISH, with S_SCAN between them, one bitmap row per cycle, when the
// written slot lies below the high mark (1 to SLOTS/ROW_W rows). req.ready is low until
// S_FINISH hands over the result, so one request is handled at a time; a result still held in
// the output register stalls the unit in S_FINISH. Synchronous reset zeroes the mark and free
// pointer, then clears the bitmap row by row (32 rows by default) with req.ready low.
`timescale 1ns / 1ps
`include "lowest_free_slot_table_unit_assert.svh"

module lowest_free_slot_table_unit import lfst_pkg::*; #(
   parameter int ROW_W = DEF_ROW_W
) (
   input  logic       clock,
   input  logic       reset,
   lfst_req_if.sink   req,
   lfst_rsp_if.source rsp
);

   localparam int BIT_W     = $clog2(ROW_W);
   localparam int ROW_IDX_W = SLOT_W - BIT_W;

   state_type             state_ff, state_in;
   logic                  op_mode_ff, op_mode_in;
   logic [VALUE_W-1:0]    op_value_ff, op_value_in;
   logic [EVENTS_W-1:0]   op_events_ff, op_events_in;
   logic [SLOT_W-1:0]     op_index_ff, op_index_in;
   logic [SLOT_W-1:0]     top_ff, top_in;
   logic [NEXT_W-1:0]     free_ff, free_in;
   logic [SLOT_W-1:0]     scan_lo_ff, scan_lo_in;
   logic [ROW_IDX_W-1:0]  scan_row_ff, scan_row_in;
   logic [ROW_IDX_W-1:0]  clr_row_ff, clr_row_in;
   status_type            res_status_ff, res_status_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [SLOT_W-1:0]     rsp_high_ff, rsp_high_in;
   logic [NEXT_W-1:0]     rsp_free_ff, rsp_free_in;

   logic                  map_wr_en;
   logic [ROW_IDX_W-1:0]  map_wr_row;
   logic [ROW_W-1:0]      map_wr_mask;
   logic [ROW_W-1:0]      map_wr_data;
   logic                  map_rd_en;
   logic [ROW_IDX_W-1:0]  map_rd_row;
   logic [ROW_W-1:0]      map_rd_data;

   logic                  ent_we;
   logic [SLOT_W-1:0]     ent_addr;
   logic [ENTRY_W-1:0]    ent_data;
   logic [ENTRY_W-1:0]    entry_mem [SLOTS];

   logic                  find_use_lo;
   logic                  find_use_hi;
   logic                  find_found;
   logic [BIT_W-1:0]      find_pos;

   logic [SLOT_W-1:0]     add_slot;
   logic [SLOT_W-1:0]     add_next;
   logic                  add_full;
   logic                  add_extend;
   logic [SLOT_W-1:0]     add_top;
   logic [ROW_W-1:0]      add_mask;
   logic [ROW_W-1:0]      rem_mask;

   lfst_valid_map #(.ROW_W(ROW_W)) u_valid_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_row  (map_wr_row),
      .wr_mask (map_wr_mask),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_row  (map_rd_row),
      .rd_data (map_rd_data)
   );

   assign find_use_lo = (scan_row_ff == scan_lo_ff[SLOT_W-1:BIT_W]);
   assign find_use_hi = (scan_row_ff == top_ff[SLOT_W-1:BIT_W]);

   lfst_find_free #(.ROW_W(ROW_W)) u_find_free (
      .row_bits (map_rd_data),
      .use_lo   (find_use_lo),
      .lo_bit   (scan_lo_ff[BIT_W-1:0]),
      .use_hi   (find_use_hi),
      .hi_bit   (top_ff[BIT_W-1:0]),
      .found    (find_found),
      .pos      (find_pos)
   );

   assign add_slot   = free_ff[SLOT_W-1:0];
   assign add_next   = add_slot + SLOT_W'(1);
   assign add_full   = (free_ff == NEXT_W'(SLOTS));
   assign add_extend = ({1'b0, add_slot} == ({1'b0, top_ff} + NEXT_W'(1)));
   assign add_top    = add_extend ? add_slot : top_ff;
   assign add_mask   = ROW_W'(1) << add_slot[BIT_W-1:0];
   assign rem_mask   = ROW_W'(1) << op_index_ff[BIT_W-1:0];

   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.used_slot = rsp_slot_ff;
   assign rsp.high_mark = rsp_high_ff;
   assign rsp.next_free = rsp_free_ff;

   always_comb begin
      state_in      = state_ff;
      op_mode_in    = op_mode_ff;
      op_value_in   = op_value_ff;
      op_events_in  = op_events_ff;
      op_index_in   = op_index_ff;
      top_in        = top_ff;
      free_in       = free_ff;
      scan_lo_in    = scan_lo_ff;
      scan_row_in   = scan_row_ff;
      clr_row_in    = clr_row_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_free_in   = rsp_free_ff;
      map_wr_en     = 1'b0;
      map_wr_row    = clr_row_ff;
      map_wr_mask   = '0;
      map_wr_data   = '0;
      map_rd_en     = 1'b0;
      map_rd_row    = op_index_ff[SLOT_W-1:BIT_W];
      ent_we        = 1'b0;
      ent_addr      = op_index_ff;
      ent_data      = '0;

      case (state_ff)
         S_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_mask = '1;
            clr_row_in  = clr_row_ff + ROW_IDX_W'(1);
            if (clr_row_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               op_mode_in   = req.mode;
               op_value_in  = req.entry_value;
               op_events_in = req.entry_events;
               op_index_in  = req.slot_index;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_mode_ff == MODE_ADD) begin
               if (add_full) begin
                  res_status_in = ST_FULL;
                  res_slot_in   = '0;
                  state_in      = S_FINISH;
               end else begin
                  map_wr_en     = 1'b1;
                  map_wr_row    = add_slot[SLOT_W-1:BIT_W];
                  map_wr_mask   = add_mask;
                  map_wr_data   = add_mask;
                  ent_we        = 1'b1;
                  ent_addr      = add_slot;
                  ent_data      = {op_events_ff, op_value_ff};
                  top_in        = add_top;
                  res_status_in = ST_OK;
                  res_slot_in   = add_slot;
                  if (add_slot < add_top) begin
                     // look for a hole between the written slot and the mark
                     scan_lo_in  = add_next;
                     scan_row_in = add_next[SLOT_W-1:BIT_W];
                     map_rd_en   = 1'b1;
                     map_rd_row  = add_next[SLOT_W-1:BIT_W];
                     state_in    = S_SCAN;
                  end else begin
                     free_in  = NEXT_W'(add_top) + NEXT_W'(1);
                     state_in = S_FINISH;
                  end
               end
            end else begin
               if (op_index_ff > top_ff) begin
                  res_status_in = ST_ABOVE;
                  res_slot_in   = '0;
                  state_in      = S_FINISH;
               end else begin
                  map_rd_en = 1'b1;
                  state_in  = S_CHECK;
               end
            end
         end
         S_SCAN: begin
            if (find_found) begin
               free_in  = NEXT_W'({scan_row_ff, find_pos});
               state_in = S_FINISH;
            end else if (find_use_hi) begin
               free_in  = NEXT_W'(top_ff) + NEXT_W'(1);
               state_in = S_FINISH;
            end else begin
               scan_row_in = scan_row_ff + ROW_IDX_W'(1);
               map_rd_en   = 1'b1;
               map_rd_row  = scan_row_ff + ROW_IDX_W'(1);
            end
         end
         S_CHECK: begin
            state_in = S_FINISH;
            if (!map_rd_data[op_index_ff[BIT_W-1:0]]) begin
               res_status_in = ST_EMPTY;
               res_slot_in   = '0;
            end else begin
               map_wr_en     = 1'b1;
               map_wr_row    = op_index_ff[SLOT_W-1:BIT_W];
               map_wr_mask   = rem_mask;
               ent_we        = 1'b1;
               res_status_in = ST_OK;
               res_slot_in   = op_index_ff;
               if (op_index_ff == top_ff) begin
                  if (free_ff == NEXT_W'(top_ff) + NEXT_W'(1)) begin
                     free_in = NEXT_W'(top_ff);
                  end
                  // the mark holds at zero when the last entry goes
                  if (top_ff != '0) begin
                     top_in = top_ff - SLOT_W'(1);
                  end
               end else if (NEXT_W'(op_index_ff) < free_ff) begin
                  free_in = NEXT_W'(op_index_ff);
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_high_in   = top_ff;
               rsp_free_in   = free_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_row_ff   <= '0;
         top_ff       <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         top_ff       <= top_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_mode_ff    <= op_mode_in;
      op_value_ff   <= op_value_in;
      op_events_ff  <= op_events_in;
      op_index_ff   <= op_index_in;
      scan_lo_ff    <= scan_lo_in;
      scan_row_ff   <= scan_row_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_free_ff   <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_addr] <= ent_data;
      end
   end

   `LFST_ASSERT_ALWAYS(a_free_within_mark, clock, reset, free_ff <= (NEXT_W'(top_ff) + NEXT_W'(1)))
   `LFST_ASSERT_NEXT(a_accept_starts_exec, clock, reset, req.valid && req.ready, state_ff == S_EXEC)
   `LFST_ASSERT_IMPLY(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FINISH)
   `LFST_ASSERT_IMPLY(a_scan_below_mark, clock, reset, state_ff == S_SCAN, scan_row_ff <= top_ff[SLOT_W-1:BIT_W])

endmodule
